// ===== sv/bbmp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbmp_pkg
// Shared sizes, codes and types of the bit-packed boolean matrix store.
// ----------------------------------------------------------------------------
package bbmp_pkg;

  // Matrix geometry: one store word packs PACK_BITS rows of one column.
  localparam int MAX_ROWS  = 256;
  localparam int MAX_COLS  = 256;
  localparam int PACK_BITS = 32;
  localparam int GROUPS    = (MAX_ROWS + PACK_BITS - 1) / PACK_BITS;
  localparam int DEPTH     = GROUPS * MAX_COLS;

  localparam int ROW_W  = 8;
  localparam int COL_W  = 8;
  localparam int GRP_W  = $clog2(GROUPS);
  localparam int BIT_W  = $clog2(PACK_BITS);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int DIM_W  = 9;

  // Operation codes carried with each input beat.
  typedef enum logic [1:0] {
    FN_CLEAR = 2'd0,
    FN_SET   = 2'd1,
    FN_READ  = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_OOB   = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_CLR,
    ST_CLR_DONE,
    ST_MODIFY,
    ST_SCAN,
    ST_REPLY
  } state_t;

endpackage : bbmp_pkg
`default_nettype wire

// ===== sv/bitpacked_bool_matrix_pack_unpack.sv =====
// Set: memory read, then modify and write back.
// Read: memory read, then one result beat per entry found in the word, or one status beat if none.
// Clear: one word per cycle over the whole store, then one status beat.
// Out-of-bounds and empty-matrix items answer with a status beat without a memory access.
// Reset clears both dimension registers and starts a clearing pass over the whole store
// during which no input beat is accepted; configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitpacked_bool_matrix_pack_unpack
// Boolean matrix kept as packed column words in one synchronous RAM: clear,
// set one entry by read-modify-write, and scan one word into coordinates.
// ----------------------------------------------------------------------------
module bitpacked_bool_matrix_pack_unpack (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Configuration write port.
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [bbmp_pkg::DIM_W-1:0]  cfg_wdata,
  // Input stream.
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [23:0]                 in_tdata,   // entry_row, entry_col, row_group, zeros
  input  wire logic [1:0]                  in_tuser,   // func
  // Result stream.
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [15:0]                      out_tdata,  // found_row, found_col
  output logic [2:0]                       out_tuser,  // status, found_valid
  output logic                             out_tlast
);

  import bbmp_pkg::*;

  // Registers.
  state_t                 state_r, state_nxt;
  logic [DIM_W-1:0]       rows_r, cols_r;
  logic [ADDR_W-1:0]      clr_cnt_r, clr_cnt_nxt;
  func_t                  op_r;
  logic [COL_W-1:0]       col_r;
  logic [GRP_W-1:0]       grp_r;
  logic [BIT_W-1:0]       bit_r;
  status_t                reply_stat_r, reply_stat_nxt;
  logic [PACK_BITS-1:0]   scan_r, scan_nxt;
  logic                   out_valid_r;
  status_t                out_stat_r;
  logic [ROW_W-1:0]       out_row_r;
  logic [COL_W-1:0]       out_col_r;
  logic                   out_fv_r, out_last_r;

  // Combinational signals.
  func_t                  in_func;
  logic [ROW_W-1:0]       in_row;
  logic [COL_W-1:0]       in_col;
  logic [GRP_W-1:0]       in_grp, grp_sel;
  logic [DIM_W-1:0]       rows_eff, cols_eff;
  logic                   accept, slot_free, is_empty, set_oob, rd_oob, sweep_last;
  logic                   ram_we, ram_re;
  logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
  logic [PACK_BITS-1:0]   ram_wdata, ram_rdata, row_mask, masked, scan_rest;
  logic [BIT_W-1:0]       low_idx;
  logic                   push, push_fv, push_last;
  status_t                push_stat;
  logic [ROW_W-1:0]       push_row;
  logic [COL_W-1:0]       push_col;

  // Store of packed column words.
  bbmp_ram #(
    .WIDTH (PACK_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Input beat fields and bounds checks.
  always_comb begin
    in_func   = func_t'(in_tuser);
    in_row    = in_tdata[ROW_W-1:0];
    in_col    = in_tdata[ROW_W+COL_W-1:ROW_W];
    in_grp    = in_tdata[ROW_W+COL_W+GRP_W-1:ROW_W+COL_W];
    grp_sel   = (in_func == FN_SET) ? in_row[ROW_W-1:BIT_W] : in_grp;
    rows_eff  = (rows_r > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_r;
    cols_eff  = (cols_r > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_r;
    is_empty  = (rows_eff == '0) || (cols_eff == '0);
    set_oob   = (DIM_W'(in_row) >= rows_eff) || (DIM_W'(in_col) >= cols_eff);
    rd_oob    = (DIM_W'(in_col) >= cols_eff) ||
                (DIM_W'({in_grp, {BIT_W{1'b0}}}) >= rows_eff);
    slot_free = !out_valid_r || out_tready;
    in_tready = (state_r == ST_IDLE);
    accept    = in_tvalid && in_tready;
    sweep_last = (clr_cnt_r == ADDR_W'(DEPTH - 1));
  end

  // Row mask of the fetched word and lowest-set-bit search for the scan.
  always_comb begin
    for (int k = 0; k < PACK_BITS; k++) begin
      row_mask[k] = (DIM_W'({grp_r, BIT_W'(k)}) < rows_eff);
    end
    masked  = ram_rdata & row_mask;
    low_idx = '0;
    for (int k = PACK_BITS - 1; k >= 0; k--) begin
      if (scan_r[k]) begin
        low_idx = BIT_W'(k);
      end
    end
    scan_rest = scan_r & ~(PACK_BITS'(1) << low_idx);
  end

  // Memory control, result generation and datapath next values.
  always_comb begin
    ram_re         = accept && !is_empty &&
                     (((in_func == FN_SET) && !set_oob) ||
                      ((in_func == FN_READ) && !rd_oob));
    ram_raddr      = {grp_sel, in_col};
    ram_we         = 1'b0;
    ram_waddr      = {grp_r, col_r};
    ram_wdata      = ram_rdata | (PACK_BITS'(1) << bit_r);
    push           = 1'b0;
    push_stat      = STAT_OK;
    push_row       = '0;
    push_col       = '0;
    push_fv        = 1'b0;
    push_last      = 1'b1;
    clr_cnt_nxt    = clr_cnt_r;
    reply_stat_nxt = reply_stat_r;
    scan_nxt       = scan_r;

    case (state_r)
      ST_INIT_CLR, ST_CLR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
      end
      ST_IDLE: begin
        clr_cnt_nxt    = '0;
        reply_stat_nxt = is_empty ? STAT_EMPTY : STAT_OOB;
      end
      ST_CLR_DONE: begin
        push = slot_free;
      end
      ST_REPLY: begin
        push      = slot_free;
        push_stat = reply_stat_r;
      end
      ST_MODIFY: begin
        if (op_r == FN_SET) begin
          push   = slot_free;
          ram_we = slot_free;
        end else begin
          scan_nxt       = masked;
          reply_stat_nxt = STAT_OK;
        end
      end
      ST_SCAN: begin
        push      = slot_free;
        push_row  = {grp_r, low_idx};
        push_col  = col_r;
        push_fv   = 1'b1;
        push_last = (scan_rest == '0);
        if (slot_free) begin
          scan_nxt = scan_rest;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT_CLR: begin
        if (sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && (in_func != FN_NONE)) begin
          if (is_empty) begin
            state_nxt = ST_REPLY;
          end else begin
            case (in_func)
              FN_CLEAR: state_nxt = ST_CLR;
              FN_SET:   state_nxt = set_oob ? ST_REPLY : ST_MODIFY;
              FN_READ:  state_nxt = rd_oob ? ST_REPLY : ST_MODIFY;
              default:  state_nxt = ST_IDLE;
            endcase
          end
        end
      end
      ST_CLR: begin
        if (sweep_last) state_nxt = ST_CLR_DONE;
      end
      ST_CLR_DONE, ST_REPLY: begin
        if (push) state_nxt = ST_IDLE;
      end
      ST_MODIFY: begin
        if (op_r == FN_SET) begin
          if (push) state_nxt = ST_IDLE;
        end else begin
          state_nxt = (masked == '0) ? ST_REPLY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (push && push_last) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT_CLR;
      clr_cnt_r   <= '0;
      rows_r      <= '0;
      cols_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (cfg_we) begin
        if (cfg_index) begin
          cols_r <= cfg_wdata;
        end else begin
          rows_r <= cfg_wdata;
        end
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item, scan and result payload registers.
  always_ff @(posedge clk) begin
    reply_stat_r <= reply_stat_nxt;
    scan_r       <= scan_nxt;
    if (accept) begin
      op_r  <= in_func;
      col_r <= in_col;
      grp_r <= grp_sel;
      bit_r <= in_row[BIT_W-1:0];
    end
    if (push) begin
      out_stat_r <= push_stat;
      out_row_r  <= push_row;
      out_col_r  <= push_col;
      out_fv_r   <= push_fv;
      out_last_r <= push_last;
    end
  end

  // Result ports.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_col_r, out_row_r};
  assign out_tuser  = {out_fv_r, out_stat_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // No beat is taken while the store is being swept.
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT_CLR || state_r == ST_CLR) |-> !in_tready)
    else $error("input beat accepted during a clearing sweep");

  // A result without an entry is always the final one of its item.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[2]) |-> out_tlast)
    else $error("status-only result not marked last");

  // A set write-back finishes the item.
  a_set_done: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r == ST_MODIFY) |=> (state_r == ST_IDLE))
    else $error("set write-back did not return to idle");

  // The scan only runs while entries remain to be reported.
  a_scan_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_r != '0))
    else $error("scan state with no entries left");
`endif

endmodule : bitpacked_bool_matrix_pack_unpack
`default_nettype wire

// ===== sv/bbmp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbmp_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module bbmp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule : bbmp_ram
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bit-packed boolean matrix store. Directed and
// random clear, set and read beats are streamed in under several idling
// patterns. A behavioural copy of the matrix predicts every result beat.
// ----------------------------------------------------------------------------
module testbench;
  import bbmp_pkg::*;

  // Register indexes of the configuration port.
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Settling time for a busy block, longer than the longest word scan.
  localparam int SETTLE_CYCLES = 40;

  // One expected or observed result beat.
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] row;
    logic [7:0] col;
    logic       valid;
    logic       last;
  } found_entry_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic                cfg_index;
  logic [DIM_W-1:0]    cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [23:0]         in_tdata;   // entry_row, entry_col, row_group, zeros
  logic [1:0]          in_tuser;   // func
  logic                out_tvalid;
  logic                out_tready;
  logic [15:0]         out_tdata;  // found_row, found_col
  logic [2:0]          out_tuser;  // status, found_valid
  logic                out_tlast;

  // Shadow of the matrix and its dimension registers.
  logic [PACK_BITS-1:0] matrix_words [DEPTH];
  logic [DIM_W-1:0]     model_rows;
  logic [DIM_W-1:0]     model_cols;
  found_entry_t         expected_entries [$];

  int fail_count;
  int send_idle_pct;
  int recv_stall_pct;

  bitpacked_bool_matrix_pack_unpack uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 2 ns clock.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Register values above the matrix size behave as the full size.
  function automatic int eff_dim(input logic [DIM_W-1:0] v, input int limit);
    return (int'(v) > limit) ? limit : int'(v);
  endfunction

  function automatic void push_entry(input status_t st, input int r, input int c,
                                     input logic v, input logic l);
    found_entry_t e;
    e.status = st;
    e.row    = r[7:0];
    e.col    = c[7:0];
    e.valid  = v;
    e.last   = l;
    expected_entries.insert(expected_entries.size(), e);
  endfunction

  // Apply one operation to the shadow matrix and queue the beats it causes.
  function automatic void predict_matrix_op(input func_t f, input logic [7:0] r,
                                            input logic [7:0] c, input logic [2:0] g);
    int rows_eff;
    int cols_eff;
    int base;
    int hits;
    logic [PACK_BITS-1:0] word;
    rows_eff = eff_dim(model_rows, MAX_ROWS);
    cols_eff = eff_dim(model_cols, MAX_COLS);
    if (f == FN_NONE) begin
      // Unused operation: nothing comes back.
    end else if (rows_eff == 0 || cols_eff == 0) begin
      push_entry(STAT_EMPTY, 0, 0, 1'b0, 1'b1);
    end else if (f == FN_CLEAR) begin
      foreach (matrix_words[i]) matrix_words[i] = '0;
      push_entry(STAT_OK, 0, 0, 1'b0, 1'b1);
    end else if (f == FN_SET) begin
      if (int'(r) >= rows_eff || int'(c) >= cols_eff) begin
        push_entry(STAT_OOB, 0, 0, 1'b0, 1'b1);
      end else begin
        matrix_words[int'(r[7:5]) * MAX_COLS + int'(c)][r[4:0]] = 1'b1;
        push_entry(STAT_OK, 0, 0, 1'b0, 1'b1);
      end
    end else begin
      base = int'(g) * PACK_BITS;
      if (int'(c) >= cols_eff || base >= rows_eff) begin
        push_entry(STAT_OOB, 0, 0, 1'b0, 1'b1);
      end else begin
        word = matrix_words[int'(g) * MAX_COLS + int'(c)];
        hits = 0;
        for (int k = 0; k < PACK_BITS; k++) begin
          if (base + k < rows_eff && word[k]) begin
            // Each hit is queued as not final; the last one is marked after the loop.
            push_entry(STAT_OK, base + k, int'(c), 1'b1, 1'b0);
            hits++;
          end
        end
        if (hits == 0) begin
          push_entry(STAT_OK, 0, 0, 1'b0, 1'b1);
        end else begin
          expected_entries[expected_entries.size() - 1].last = 1'b1;
        end
      end
    end
  endfunction

  // Receiver: random back-pressure at the falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin : check_results
    found_entry_t got;
    found_entry_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser[1:0];
      got.row    = out_tdata[7:0];
      got.col    = out_tdata[15:8];
      got.valid  = out_tuser[2];
      got.last   = out_tlast;
      if (expected_entries.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected beat status=%0d row=%0d col=%0d valid=%0b last=%0b",
                   $realtime, got.status, got.row, got.col, got.valid, got.last);
      end else begin
        want = expected_entries.pop_front();
        if (got.status !== want.status || got.row !== want.row || got.col !== want.col ||
            got.valid !== want.valid || got.last !== want.last) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: mismatch exp status=%0d row=%0d col=%0d valid=%0b last=%0b,",
                     $realtime, want.status, want.row, want.col, want.valid, want.last);
            $display("  got status=%0d row=%0d col=%0d valid=%0b last=%0b",
                     got.status, got.row, got.col, got.valid, got.last);
          end
        end
      end
    end
  end

  // Send one beat; called and returning at a falling edge.
  task automatic send_beat(input func_t f, input logic [7:0] r, input logic [7:0] c,
                           input logic [2:0] g);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, g, c, r};
    in_tuser  <= f;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_matrix_op(f, r, c, g);
    @(negedge clk);
  endtask

  // Drop valid and let every outstanding result drain before a register write.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_entries.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write both dimension registers on consecutive cycles.
  task automatic set_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS;
    cfg_wdata <= rows;
    @(negedge clk);
    cfg_index <= REG_COLS;
    cfg_wdata <= cols;
    @(negedge clk);
    cfg_we    <= 1'b0;
    model_rows = rows;
    model_cols = cols;
  endtask

  // Empty matrix, bounds, row masking, word scans and oversized registers.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Both dimensions zero after reset.
    send_beat(FN_CLEAR, 8'd0, 8'd0, 3'd0);
    send_beat(FN_SET, 8'd0, 8'd0, 3'd0);
    send_beat(FN_READ, 8'd0, 8'd0, 3'd0);
    send_beat(FN_NONE, 8'd255, 8'd255, 3'd7);
    wait_idle();
    set_dims(9'd256, 9'd0);
    send_beat(FN_SET, 8'd3, 8'd3, 3'd0);
    wait_idle();
    // Full-size matrix: corners, group boundary and a few neighbours.
    set_dims(9'd256, 9'd256);
    send_beat(FN_SET, 8'd0, 8'd0, 3'd0);
    send_beat(FN_SET, 8'd255, 8'd255, 3'd0);
    send_beat(FN_SET, 8'd31, 8'd0, 3'd0);
    send_beat(FN_SET, 8'd32, 8'd0, 3'd0);
    send_beat(FN_SET, 8'd45, 8'd2, 3'd0);
    send_beat(FN_SET, 8'd39, 8'd2, 3'd0);
    send_beat(FN_READ, 8'd0, 8'd0, 3'd0);
    send_beat(FN_READ, 8'd0, 8'd0, 3'd1);
    send_beat(FN_READ, 8'd0, 8'd255, 3'd7);
    send_beat(FN_READ, 8'd0, 8'd9, 3'd3);
    wait_idle();
    // Shrunk matrix: rows past the count are hidden, bounds give errors.
    set_dims(9'd40, 9'd200);
    send_beat(FN_READ, 8'd0, 8'd2, 3'd1);
    send_beat(FN_SET, 8'd40, 8'd0, 3'd0);
    send_beat(FN_SET, 8'd0, 8'd200, 3'd0);
    send_beat(FN_READ, 8'd0, 8'd0, 3'd2);
    send_beat(FN_READ, 8'd0, 8'd200, 3'd0);
    wait_idle();
    // Register values above the matrix size act as the full size.
    set_dims(9'd511, 9'd511);
    send_beat(FN_READ, 8'd0, 8'd2, 3'd1);
    send_beat(FN_SET, 8'd255, 8'd255, 3'd0);
    send_beat(FN_CLEAR, 8'd0, 8'd0, 3'd0);
    send_beat(FN_READ, 8'd0, 8'd0, 3'd0);
  endtask

  // Fill one word completely, then scan it whole and with a partial row count.
  task automatic test_full_word();
    logic [4:0] order [PACK_BITS];
    logic [4:0] tmp;
    int j;
    wait_idle();
    set_dims(9'd256, 9'd256);
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    foreach (order[i]) order[i] = i[4:0];
    foreach (order[i]) begin
      j        = $urandom_range(0, PACK_BITS - 1);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) send_beat(FN_SET, {3'd4, order[i]}, 8'd7, 3'd0);
    send_beat(FN_READ, 8'd0, 8'd7, 3'd4);
    wait_idle();
    set_dims(9'd150, 9'd8);
    send_beat(FN_READ, 8'd0, 8'd7, 3'd4);
  endtask

  // Mostly well-formed sets and reads aimed at a few dense words, some noise.
  task automatic test_random_phase(input int n_items, input int idle_pct,
                                   input int stall_pct, input logic [DIM_W-1:0] rows,
                                   input logic [DIM_W-1:0] cols);
    int rows_eff;
    int cols_eff;
    int grp_max;
    int hot_cols;
    int pick;
    int g;
    int r;
    int c;
    wait_idle();
    set_dims(rows, cols);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    rows_eff = eff_dim(rows, MAX_ROWS);
    cols_eff = eff_dim(cols, MAX_COLS);
    grp_max  = (rows_eff - 1) / PACK_BITS;
    hot_cols = (cols_eff < 4) ? cols_eff : 4;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      g = ($urandom_range(0, 99) < 70) ? $urandom_range(0, (grp_max < 1) ? grp_max : 1)
                                       : $urandom_range(0, grp_max);
      c = ($urandom_range(0, 99) < 80) ? $urandom_range(0, hot_cols - 1)
                                       : $urandom_range(0, cols_eff - 1);
      r = g * PACK_BITS + $urandom_range(0, PACK_BITS - 1);
      if (r >= rows_eff) r = rows_eff - 1;
      if (pick < 1) begin
        send_beat(FN_CLEAR, 8'd0, 8'd0, 3'd0);
      end else if (pick < 50) begin
        send_beat(FN_SET, r[7:0], c[7:0], 3'($urandom_range(0, 7)));
      end else if (pick < 85) begin
        send_beat(FN_READ, 8'($urandom_range(0, 255)), c[7:0], g[2:0]);
      end else begin
        send_beat(func_t'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_ROWS;
    cfg_wdata      = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = FN_NONE;
    out_tready     = 1'b1;
    fail_count     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    model_rows     = '0;
    model_cols     = '0;
    foreach (matrix_words[i]) matrix_words[i] = '0;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_full_word();
    test_random_phase(110, 0, 0, 9'd256, 9'd256);
    test_random_phase(110, 71, 0, 9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)));
    test_random_phase(110, 0, 71, 9'd511, 9'd300);
    test_random_phase(110, 38, 38, 9'd33, 9'd5);

    wait_idle();
    if (fail_count == 0 && expected_entries.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bbmp_pkg.sv
sv/bbmp_ram.sv
sv/bitpacked_bool_matrix_pack_unpack.sv
sim/testbench.sv
